// ===== src/tpq_pkg.sv =====
// Shared types and constants for the timed priority packet queue.
package tpq_pkg;

	localparam int DEPTH_DEF = 32;
	localparam logic [5:0] CAP_RESET = 6'd32;

	// command codes
	localparam logic [2:0] CMD_ADD    = 3'd0;
	localparam logic [2:0] CMD_POP    = 3'd1;
	localparam logic [2:0] CMD_QUERY  = 3'd2;
	localparam logic [2:0] CMD_PEEK   = 3'd3;
	localparam logic [2:0] CMD_REMOVE = 3'd4;

	// status codes
	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_FULL   = 2'd1;
	localparam logic [1:0] STAT_NONE   = 2'd2;
	localparam logic [1:0] STAT_BADIDX = 2'd3;

	typedef struct packed {
		logic [7:0]  hnd;
		logic [7:0]  pri;
		logic [31:0] rel;
	} entry_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_ROTATE,
		OP_COMPACT,
		OP_WRITE
	} cell_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH,
		ST_COMPACT,
		ST_DONE
	} state_t;

endpackage

// ===== src/tpq_cell.sv =====
// One entry cell: wr_entry on write, neighbor's on rotate/compact.
module tpq_cell import tpq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int IDX = 0,
	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  cell_op_t      op,
	input  logic [IW-1:0] k,
	input  entry_t        wr_entry,
	input  entry_t        nb_entry,
	output entry_t        entry
);

	entry_t entry_q;

	// entry update by operation
	always_ff @(posedge clk) begin
		case (op)
			OP_ROTATE: entry_q <= nb_entry;
			OP_COMPACT: begin
				if (IW'(IDX) >= k) entry_q <= nb_entry;
			end
			OP_WRITE: begin
				if (IW'(IDX) == k) entry_q <= wr_entry;
			end
			default: ;
		endcase
	end

	assign entry = entry_q;

endmodule

// ===== src/timed_priority_packet_queue.sv =====
// Top level: timed priority packet queue built as a ring of entry cells.
// Add, unused codes and bad index go straight to the result state; pop, query, peek and
// remove rotate the ring once in the scan state, then finish; a found pop or a remove compacts.
// One transaction at a time: no new command is taken until the result is accepted; the scan
// is set by the ring rotation that presents one entry per cycle at cell 0.
// Reset: arst_n clears entry count, state and sets capacity to 32; entry cells are not cleared.
module timed_priority_packet_queue import tpq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [5:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// command[2:0], handle[10:3], priority_req[18:11], release_time[50:19],
	// time_now[82:51], entry_index[87:83]
	input  logic [87:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status[1:0], handle_out[9:2], ready_count[15:10], next_time[47:16],
	// next_valid[48], occupancy[54:49], zero[55]
	output logic [55:0] m_tdata
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	state_t state_q, state_d;
	logic [CW-1:0] count_q, s_q, rc_q;
	logic [5:0] cap_q;
	logic [2:0] cmd_q;
	logic [31:0] now_q, nt_q;
	logic [4:0] idx_q;
	logic found_q, anydue_q;
	logic [IW-1:0] best_q, k_q, k;
	logic [7:0] bpri_q, bhnd_q, hcap_q;
	logic [1:0] ost_q;
	logic [7:0] ohnd_q;
	logic [5:0] orc_q;
	logic [31:0] ont_q;
	logic onv_q;

	cell_op_t op;
	entry_t cells [DEPTH];
	entry_t wr_entry, head;

	logic in_acc, out_acc;
	logic [2:0] in_cmd;
	logic [4:0] in_idx;
	logic [8:0] cnt9, cap9, capeff, in_idx9;
	logic full, bad_in;
	logic live, due, earlier, scan_last;
	logic [31:0] d_now, d_nt;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;
	assign cfg_ready = 1'b1;
	assign in_cmd = s_tdata[2:0];
	assign in_idx = s_tdata[87:83];
	assign wr_entry = '{hnd: s_tdata[10:3], pri: s_tdata[18:11], rel: s_tdata[50:19]};

	// capacity clamp and request checks
	assign cnt9 = 9'(count_q);
	assign cap9 = {3'b000, cap_q};
	assign capeff = (cap9 > 9'(DEPTH)) ? 9'(DEPTH) : cap9;
	assign full = cnt9 >= capeff;
	assign in_idx9 = {4'b0000, in_idx};
	assign bad_in = in_idx9 >= cnt9;

	// scan of the entry at the ring head
	assign head = cells[0];
	assign live = s_q < count_q;
	assign d_now = head.rel - now_q;
	assign due = (d_now == 32'd0) || d_now[31];
	assign d_nt = head.rel - nt_q;
	assign earlier = (s_q == '0) || d_nt[31];
	assign scan_last = s_q == CW'(DEPTH - 1);

	// ring of cells
	for (genvar j = 0; j < DEPTH; j++) begin : g_cell
		tpq_cell #(.DEPTH(DEPTH), .IDX(j)) u_cell (
			.clk      (clk),
			.op       (op),
			.k        (k),
			.wr_entry (wr_entry),
			.nb_entry (cells[(j + 1) % DEPTH]),
			.entry    (cells[j])
		);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (in_cmd == CMD_POP || in_cmd == CMD_QUERY) state_d = ST_SCAN;
					else if ((in_cmd == CMD_PEEK || in_cmd == CMD_REMOVE) && !bad_in)
						state_d = ST_SCAN;
					else state_d = ST_DONE;
				end
			end
			ST_SCAN: begin
				if (scan_last) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if ((cmd_q == CMD_POP && found_q) || cmd_q == CMD_REMOVE)
					state_d = ST_COMPACT;
				else state_d = ST_DONE;
			end
			ST_COMPACT: state_d = ST_DONE;
			ST_DONE: begin
				if (out_acc) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and cell control
	always_comb begin
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		op = OP_HOLD;
		k = k_q;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				k = count_q[IW-1:0];
				if (s_tvalid && in_cmd == CMD_ADD && !full) op = OP_WRITE;
			end
			ST_SCAN: op = OP_ROTATE;
			ST_COMPACT: op = OP_COMPACT;
			ST_DONE: m_tvalid = 1'b1;
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			cap_q <= CAP_RESET;
		end else begin
			state_q <= state_d;
			if (cfg_valid) cap_q <= cfg_data;
			if (state_q == ST_IDLE && in_acc && in_cmd == CMD_ADD && !full)
				count_q <= count_q + 1'b1;
			if (state_q == ST_COMPACT) count_q <= count_q - 1'b1;
		end
	end

	// request, scan and result registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					cmd_q <= in_cmd;
					now_q <= s_tdata[82:51];
					idx_q <= in_idx;
					k_q <= IW'(in_idx);
					s_q <= '0;
					rc_q <= '0;
					found_q <= 1'b0;
					anydue_q <= 1'b0;
					nt_q <= '0;
					ost_q <= STAT_OK;
					ohnd_q <= '0;
					orc_q <= '0;
					ont_q <= '0;
					onv_q <= 1'b0;
					if (in_cmd == CMD_ADD && full) ost_q <= STAT_FULL;
					if ((in_cmd == CMD_PEEK || in_cmd == CMD_REMOVE) && bad_in)
						ost_q <= STAT_BADIDX;
				end
			end
			ST_SCAN: begin
				s_q <= s_q + 1'b1;
				if (live) begin
					if (due) begin
						rc_q <= rc_q + 1'b1;
						anydue_q <= 1'b1;
						if (!found_q || head.pri < bpri_q) begin
							found_q <= 1'b1;
							best_q <= s_q[IW-1:0];
							bpri_q <= head.pri;
							bhnd_q <= head.hnd;
						end
					end else if (!anydue_q && earlier) begin
						nt_q <= head.rel;
					end
					if (9'(s_q) == {4'b0000, idx_q}) hcap_q <= head.hnd;
				end
			end
			ST_FINISH: begin
				case (cmd_q)
					CMD_POP: begin
						if (found_q) begin
							ohnd_q <= bhnd_q;
							k_q <= best_q;
						end else begin
							ost_q <= STAT_NONE;
						end
					end
					CMD_QUERY: begin
						orc_q <= (now_q == 32'hFFFF_FFFF) ? 6'(count_q) : 6'(rc_q);
						if (count_q == '0) begin
							ost_q <= STAT_NONE;
						end else begin
							onv_q <= 1'b1;
							ont_q <= anydue_q ? now_q : nt_q;
						end
					end
					CMD_PEEK, CMD_REMOVE: ohnd_q <= hcap_q;
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	assign m_tdata = {1'b0, 6'(count_q), onv_q, ont_q, orc_q, ohnd_q, ost_q};

	// checks
	a_no_accept_while_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid) else $error("input taken while result pending");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		9'(count_q) <= 9'(DEPTH)) else $error("entry count above depth");
	a_compact_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMPACT) |-> $past(state_q) == ST_FINISH)
		else $error("compaction without scan");
	a_compact_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMPACT) |-> count_q != '0) else $error("compaction on empty queue");

endmodule

// ===== tb/sv/timed_priority_packet_queue_checker.sv =====
// Checker for the timed priority packet queue: predicts each response and compares it.
`timescale 1ns / 1ps
module timed_priority_packet_queue_checker import tpq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [5:0]  cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [87:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [55:0] m_tdata,
	output int          fail_count,
	output int          pending_count,
	output int          resp_count
);

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  hnd;
		logic [5:0]  rcount;
		logic [31:0] ntime;
		logic        nvalid;
		logic [5:0]  occ;
	} resp_t;

	// shadow table
	logic [7:0]  q_hnd [32];
	logic [7:0]  q_pri [32];
	logic [31:0] q_rel [32];
	int          q_count;
	logic [5:0]  q_cap;
	resp_t       expected_q [$];

	assign pending_count = expected_q.size();

	function automatic bit due(logic [31:0] rel, logic [31:0] now);
		logic [31:0] d;
		d = rel - now;
		return d == 0 || d[31];
	endfunction

	task automatic drop_entry(int idx);
		q_count--;
		for (int j = idx; j < q_count; j++) begin
			q_hnd[j] = q_hnd[j + 1];
			q_pri[j] = q_pri[j + 1];
			q_rel[j] = q_rel[j + 1];
		end
	endtask

	// compute response for one command transaction
	task automatic predict_queue(logic [87:0] d);
		logic [2:0]  cmd;
		logic [31:0] now;
		logic [31:0] c;
		int          idx;
		int          cap;
		int          best;
		bit          any;
		resp_t       r;
		cmd = d[2:0];
		now = d[82:51];
		idx = int'(d[87:83]);
		cap = (q_cap > 6'd32) ? 32 : int'(q_cap);
		r = '0;
		r.status = STAT_OK;
		case (cmd)
			CMD_ADD: begin
				if (q_count >= cap) r.status = STAT_FULL;
				else begin
					q_hnd[q_count] = d[10:3];
					q_pri[q_count] = d[18:11];
					q_rel[q_count] = d[50:19];
					q_count++;
				end
			end
			CMD_POP: begin
				best = -1;
				for (int j = 0; j < q_count; j++)
					if (due(q_rel[j], now) && (best < 0 || q_pri[j] < q_pri[best]))
						best = j;
				if (best < 0) r.status = STAT_NONE;
				else begin
					r.hnd = q_hnd[best];
					drop_entry(best);
				end
			end
			CMD_QUERY: begin
				if (now == 32'hFFFF_FFFF) r.rcount = 6'(q_count);
				else
					for (int j = 0; j < q_count; j++)
						if (due(q_rel[j], now)) r.rcount++;
				if (q_count == 0) r.status = STAT_NONE;
				else begin
					r.nvalid = 1'b1;
					any = 1'b0;
					for (int j = 0; j < q_count; j++) begin
						c = q_rel[j];
						if (due(c, now)) begin
							any = 1'b1;
							break;
						end
						if (j == 0 || ((c - r.ntime) & 32'h8000_0000) != 0) r.ntime = c;
					end
					if (any) r.ntime = now;
				end
			end
			CMD_PEEK, CMD_REMOVE: begin
				if (idx >= q_count) r.status = STAT_BADIDX;
				else begin
					r.hnd = q_hnd[idx];
					if (cmd == CMD_REMOVE) drop_entry(idx);
				end
			end
			default: ;
		endcase
		r.occ = 6'(q_count);
		expected_q.push_back(r);
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch: response %0d %s got %0h expected %0h", resp_count, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		resp_t got;
		resp_t want;
		if (!arst_n) begin
			q_count = 0;
			q_cap = CAP_RESET;
			fail_count = 0;
			resp_count = 0;
			expected_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) q_cap = cfg_data;
			// output first: response to an earlier command never sees this one
			if (m_tvalid && m_tready) begin
				got.status = m_tdata[1:0];
				got.hnd = m_tdata[9:2];
				got.rcount = m_tdata[15:10];
				got.ntime = m_tdata[47:16];
				got.nvalid = m_tdata[48];
				got.occ = m_tdata[54:49];
				if (expected_q.size() == 0) begin
					report_mismatch("unexpected response", m_tdata[31:0], 32'd0);
				end else begin
					want = expected_q.pop_front();
					if (got.status != want.status)
						report_mismatch("status", 32'(got.status), 32'(want.status));
					if (got.hnd != want.hnd)
						report_mismatch("handle_out", 32'(got.hnd), 32'(want.hnd));
					if (got.rcount != want.rcount)
						report_mismatch("ready_count", 32'(got.rcount), 32'(want.rcount));
					if (got.ntime != want.ntime) report_mismatch("next_time", got.ntime, want.ntime);
					if (got.nvalid != want.nvalid)
						report_mismatch("next_valid", 32'(got.nvalid), 32'(want.nvalid));
					if (got.occ != want.occ)
						report_mismatch("occupancy", 32'(got.occ), 32'(want.occ));
				end
				resp_count++;
			end
			if (s_tvalid && s_tready) predict_queue(s_tdata);
		end
	end

endmodule

// ===== tb/sv/timed_priority_packet_queue_test.sv =====
// Testbench top for the timed priority packet queue: stimulus, pacing and verdict.
`timescale 1ns / 1ps
module timed_priority_packet_queue_test;
	import tpq_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [5:0]  cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [87:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;
	int          fail_count;
	int          pending_count;
	int          resp_count;

	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          recv_hold = 0;
	int          live_count = 0;
	int          sent_count = 0;
	logic [31:0] base_time = '0;

	always #5 clk = ~clk;

	timed_priority_packet_queue dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	timed_priority_packet_queue_checker chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.fail_count(fail_count), .pending_count(pending_count), .resp_count(resp_count)
	);

	// receiver: random stalls, or a counted long hold-off
	always @(negedge clk) begin
		if (recv_hold > 0) begin
			m_tready <= 1'b0;
			recv_hold <= recv_hold - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// one command transaction; random gap before it, valid stays up until the next step
	task automatic send_cmd(logic [2:0] cmd, logic [7:0] hnd, logic [7:0] pri,
			logic [31:0] rel, logic [31:0] now, logic [4:0] idx);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tdata <= {idx, now, rel, pri, hnd, cmd};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		sent_count++;
		if (cmd == CMD_ADD) live_count++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_count != 0) @(negedge clk);
		repeat (50) @(negedge clk);
	endtask

	task automatic write_capacity(logic [5:0] value);
		wait_drained();
		cfg_data <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// mostly adds and pops near base_time, some odd commands and indexes
	task automatic random_cmd();
		int          pick;
		logic [2:0]  cmd;
		logic [31:0] now;
		pick = $urandom_range(99);
		if (pick < 40) cmd = CMD_ADD;
		else if (pick < 62) cmd = CMD_POP;
		else if (pick < 76) cmd = CMD_QUERY;
		else if (pick < 85) cmd = CMD_PEEK;
		else if (pick < 96) cmd = CMD_REMOVE;
		else cmd = 3'($urandom_range(7, 5));
		now = ($urandom_range(9) == 0) ? $urandom() : base_time + $urandom_range(40);
		if ($urandom_range(19) == 0) now = 32'hFFFF_FFFF;
		send_cmd(cmd, 8'($urandom()),
			($urandom_range(3) == 0) ? 8'($urandom()) : 8'($urandom_range(7)),
			($urandom_range(7) == 0) ? $urandom() : base_time + $urandom_range(60),
			now, ($urandom_range(3) == 0) ? 5'($urandom()) : 5'($urandom_range(8)));
		base_time += $urandom_range(3);
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// directed: empty queue cases, extremes, priority 255, wraparound
		send_cmd(CMD_QUERY, 0, 0, 0, 0, 0);
		send_cmd(CMD_POP, 0, 0, 0, 0, 0);
		send_cmd(CMD_PEEK, 0, 0, 0, 0, 0);
		send_cmd(CMD_REMOVE, 0, 0, 0, 0, 31);
		send_cmd(CMD_ADD, 8'hFF, 8'hFF, 32'hFFFF_FFF0, 0, 0);
		send_cmd(CMD_ADD, 8'h00, 8'hFF, 32'h0000_0010, 0, 0);
		send_cmd(CMD_ADD, 8'h5A, 8'h00, 32'h7FFF_FFFF, 0, 0);
		send_cmd(CMD_ADD, 8'hA5, 8'h80, 32'h8000_0000, 0, 0);
		send_cmd(CMD_QUERY, 0, 0, 0, 32'hFFFF_FFE0, 0);
		send_cmd(CMD_QUERY, 0, 0, 0, 32'hFFFF_FFFF, 0);
		send_cmd(CMD_QUERY, 0, 0, 0, 32'h0000_0010, 0);
		send_cmd(CMD_PEEK, 0, 0, 0, 0, 3);
		send_cmd(CMD_PEEK, 0, 0, 0, 0, 4);
		send_cmd(CMD_POP, 0, 0, 0, 32'h0000_0000, 0);
		send_cmd(CMD_POP, 0, 0, 0, 32'h0000_0020, 0);
		send_cmd(CMD_POP, 0, 0, 0, 32'h0000_0020, 0);
		send_cmd(CMD_REMOVE, 0, 0, 0, 0, 1);
		send_cmd(CMD_REMOVE, 0, 0, 0, 0, 0);
		send_cmd(3'd5, 8'hFF, 8'hFF, '1, '1, '1);
		send_cmd(3'd7, 0, 0, 0, 0, 0);

		// capacity 0 and fill to capacity 2 then shrink below occupancy
		write_capacity(6'd0);
		send_cmd(CMD_ADD, 1, 1, 0, 0, 0);
		write_capacity(6'd2);
		repeat (3) send_cmd(CMD_ADD, 2, 2, 0, 0, 0);
		write_capacity(6'd1);
		send_cmd(CMD_ADD, 3, 3, 0, 0, 0);
		write_capacity(6'd63);
		for (int k = 0; k < 33; k++) send_cmd(CMD_ADD, 8'(k), 8'(k), 32'(k), 0, 0);
		send_cmd(CMD_PEEK, 0, 0, 0, 0, 31);
		send_cmd(CMD_QUERY, 0, 0, 0, 32'd100, 0);

		// long receiver hold-off while the sender keeps offering
		recv_hold = 300;
		repeat (12) send_cmd(CMD_POP, 0, 0, 0, 32'd100, 0);
		wait_drained();
		// clear out leftovers
		repeat (34) send_cmd(CMD_REMOVE, 0, 0, 0, 0, 0);

		// random phases with varying pacing and capacity
		send_idle_pct = 28; recv_idle_pct = 74;
		write_capacity(6'd8);
		repeat (250) random_cmd();
		write_capacity(6'd32);
		repeat (200) random_cmd();
		send_idle_pct = 74; recv_idle_pct = 28;
		write_capacity(6'd3);
		repeat (200) random_cmd();
		write_capacity(6'd40);
		repeat (200) random_cmd();
		send_idle_pct = 0; recv_idle_pct = 0;
		write_capacity(6'd16);
		repeat (200) random_cmd();
		write_capacity(6'd32);
		repeat (150) random_cmd();

		wait_drained();
		$display("ran %0d commands, %0d responses checked, capacities 0..63 incl. overflow",
			sent_count, resp_count);
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// timeout
	initial begin
		#20ms;
		$display("timeout after %0d responses", resp_count);
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== timed_priority_packet_queue.f =====
src/tpq_pkg.sv
src/tpq_cell.sv
src/timed_priority_packet_queue.sv
tb/sv/timed_priority_packet_queue_checker.sv
tb/sv/timed_priority_packet_queue_test.sv
